[hw/rtl/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared constants, types and tables for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

    // Register stages from input to output register.
    localparam int NUM_STAGES = 8;

    // Reciprocals for exact division by constants.
    // The product is followed by a right shift of the given amount.
    localparam logic [25:0] DAY_RECIP   = 26'd50903317; // 1/675, input is seconds / 128
    localparam int          DAY_SHIFT   = 35;
    localparam logic [9:0]  DAY_DIV     = 10'd675;
    localparam logic [17:0] HOUR_RECIP  = 18'd149131;   // 1/3600
    localparam int          HOUR_SHIFT  = 29;
    localparam logic [11:0] SECS_HOUR   = 12'd3600;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;     // 1/60
    localparam int          MIN_SHIFT   = 18;
    localparam logic [5:0]  SECS_MIN    = 6'd60;
    localparam logic [15:0] CYCLE_RECIP = 16'd45934;    // 1/1461
    localparam int          CYCLE_SHIFT = 26;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [16:0] WEEK_RECIP  = 17'd74899;    // 1/7
    localparam int          WEEK_SHIFT  = 19;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;

    // Day counts are rebased to 1968-01-01, the start of a four-year cycle.
    localparam logic [15:0] BASE_OFFSET = 16'd731;
    // First day after February 28, 2100 in the rebased count.
    localparam logic [15:0] SKIP_2100   = 16'd48272;
    localparam logic [5:0]  CYCLE_2100  = 6'd33;
    localparam logic [7:0]  BASE_YEAR   = 8'd68;        // 1968 - 1900
    localparam logic [2:0]  WEEK_OFFSET = 3'd4;         // epoch day was a Thursday
    localparam logic [8:0]  LEAP_DAY    = 9'd59;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } date_t;

    // First day of year of each month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/ecal_day_split.sv]
// ----------------------------------------------------------------------------
// ecal_day_split
// Splits the second count into whole days and seconds of the day.
// ----------------------------------------------------------------------------
module ecal_day_split (
    input  logic        aclk,
    input  logic [2:1]  stage_en,
    input  logic [31:0] epoch_seconds,
    output logic [16:0] day_secs,
    output logic [15:0] week_days,
    output logic [15:0] cycle_days
);
    import ecal_pkg::*;

    logic [50:0] day_prod;
    logic [15:0] days_next;
    logic [15:0] days_reg;
    logic [9:0]  xlo_reg;
    logic [6:0]  tlo_reg;
    logic [25:0] back_prod;
    logic [9:0]  rem_hi;
    logic [15:0] base_days;
    logic [16:0] rem_next;
    logic [15:0] wk_next;
    logic [15:0] dp_next;
    logic [16:0] rem_reg;
    logic [15:0] wk_reg;
    logic [15:0] dp_reg;

    // Divide by 86400 as a shift by 7 and an exact reciprocal of 675.
    assign day_prod  = 51'(epoch_seconds[31:7]) * 51'(DAY_RECIP);
    assign days_next = day_prod[DAY_SHIFT+15:DAY_SHIFT];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            days_reg <= days_next;
            xlo_reg  <= epoch_seconds[16:7];
            tlo_reg  <= epoch_seconds[6:0];
        end
    end

    // The remainder of the division by 675 fits in ten bits.
    assign back_prod = 26'(days_reg) * 26'(DAY_DIV);
    assign rem_hi    = xlo_reg - back_prod[9:0];
    assign rem_next  = {rem_hi, tlo_reg};
    assign wk_next   = days_reg + 16'(WEEK_OFFSET);
    assign base_days = days_reg + BASE_OFFSET;

    // 2100 is not a leap year: skip its February 29 so that the four-year
    // cycle arithmetic stays uniform.
    assign dp_next = (base_days >= SKIP_2100) ? base_days + 16'd1 : base_days;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            rem_reg <= rem_next;
            wk_reg  <= wk_next;
            dp_reg  <= dp_next;
        end
    end

    assign day_secs   = rem_reg;
    assign week_days  = wk_reg;
    assign cycle_days = dp_reg;

endmodule

[hw/rtl/ecal_tod.sv]
// ----------------------------------------------------------------------------
// ecal_tod
// Breaks the seconds of the day into hour, minute and second.
// ----------------------------------------------------------------------------
module ecal_tod (
    input  logic                  aclk,
    input  logic [8:3]            stage_en,
    input  logic [16:0]           day_secs,
    output ecal_pkg::tod_t        tod
);
    import ecal_pkg::*;

    logic [34:0] hr_prod;
    logic [4:0]  hr3_reg;
    logic [11:0] rem3_reg;
    logic [16:0] hr_back;
    logic [4:0]  hr4_reg;
    logic [11:0] rem4_reg;
    logic [24:0] min_prod;
    logic [4:0]  hr5_reg;
    logic [5:0]  min5_reg;
    logic [5:0]  rem5_reg;
    logic [11:0] min_back;
    tod_t        tod6_reg;
    tod_t        tod7_reg;
    tod_t        tod8_reg;

    assign hr_prod = 35'(day_secs) * 35'(HOUR_RECIP);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            hr3_reg  <= hr_prod[HOUR_SHIFT+4:HOUR_SHIFT];
            rem3_reg <= day_secs[11:0];
        end
    end

    // The seconds within the hour stay below 3600, so twelve bits suffice.
    assign hr_back = 17'(hr3_reg) * 17'(SECS_HOUR);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            hr4_reg  <= hr3_reg;
            rem4_reg <= rem3_reg - hr_back[11:0];
        end
    end

    assign min_prod = 25'(rem4_reg) * 25'(MIN_RECIP);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            hr5_reg  <= hr4_reg;
            min5_reg <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
            rem5_reg <= rem4_reg[5:0];
        end
    end

    assign min_back = 12'(min5_reg) * 12'(SECS_MIN);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            tod6_reg.hour   <= hr5_reg;
            tod6_reg.minute <= min5_reg;
            tod6_reg.second <= rem5_reg - min_back[5:0];
        end
        if (stage_en[7]) begin
            tod7_reg <= tod6_reg;
        end
        if (stage_en[8]) begin
            tod8_reg <= tod7_reg;
        end
    end

    assign tod = tod8_reg;

endmodule

[hw/rtl/ecal_date.sv]
// ----------------------------------------------------------------------------
// ecal_date
// Turns the day count into weekday, year, day of year, month and day.
// ----------------------------------------------------------------------------
module ecal_date (
    input  logic                  aclk,
    input  logic [8:3]            stage_en,
    input  logic [15:0]           week_days,
    input  logic [15:0]           cycle_days,
    output ecal_pkg::date_t       date
);
    import ecal_pkg::*;

    logic [31:0] cyc_prod;
    logic [32:0] wk_prod;
    logic [5:0]  c3_reg;
    logic [10:0] dp3_reg;
    logic [2:0]  q7_reg;
    logic [2:0]  wk3_reg;
    logic [16:0] cyc_back;
    logic [5:0]  wk_back;
    logic [5:0]  c4_reg;
    logic [10:0] r4_reg;
    logic [2:0]  wday4_reg;
    logic [1:0]  y1_next;
    logic [10:0] doy_next;
    logic [5:0]  c5_reg;
    logic [1:0]  y1_reg;
    logic [8:0]  doy_reg;
    logic [2:0]  wday5_reg;
    logic        lp_cal;
    logic        is_2100;
    logic [2:0]  wday6_reg;
    logic [7:0]  ys6_reg;
    logic [8:0]  yday6_reg;
    logic [8:0]  d26_reg;
    logic        feb6_reg;
    logic [3:0]  mon_next;
    logic [2:0]  wday7_reg;
    logic [7:0]  ys7_reg;
    logic [8:0]  yday7_reg;
    logic [8:0]  d27_reg;
    logic        feb7_reg;
    logic [3:0]  mon7_reg;
    logic [8:0]  mday_full;
    date_t       date8_reg;

    // Four-year cycles since 1968 and the week count, both exact reciprocals.
    assign cyc_prod = 32'(cycle_days) * 32'(CYCLE_RECIP);
    assign wk_prod  = 33'(week_days) * 33'(WEEK_RECIP);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            c3_reg  <= cyc_prod[CYCLE_SHIFT+5:CYCLE_SHIFT];
            dp3_reg <= cycle_days[10:0];
            q7_reg  <= wk_prod[WEEK_SHIFT+2:WEEK_SHIFT];
            wk3_reg <= week_days[2:0];
        end
    end

    // Both remainders are known to be small, so only the low bits are formed.
    assign cyc_back = 17'(c3_reg) * 17'(CYCLE_DAYS);
    assign wk_back  = 6'(q7_reg) * 6'(WEEK_DAYS);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            c4_reg    <= c3_reg;
            r4_reg    <= dp3_reg - cyc_back[10:0];
            wday4_reg <= wk3_reg - wk_back[2:0];
        end
    end

    // The first year of each cycle is the leap year.
    always_comb begin
        if (r4_reg < 11'd366) begin
            y1_next  = 2'd0;
            doy_next = r4_reg;
        end else if (r4_reg < 11'd731) begin
            y1_next  = 2'd1;
            doy_next = r4_reg - 11'd366;
        end else if (r4_reg < 11'd1096) begin
            y1_next  = 2'd2;
            doy_next = r4_reg - 11'd731;
        end else begin
            y1_next  = 2'd3;
            doy_next = r4_reg - 11'd1096;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            c5_reg    <= c4_reg;
            y1_reg    <= y1_next;
            doy_reg   <= doy_next[8:0];
            wday5_reg <= wday4_reg;
        end
    end

    // Year 2100 runs on the leap calendar with its February 29 skipped, so
    // its true day of year is one less from March on.
    assign lp_cal  = (y1_reg == 2'd0);
    assign is_2100 = lp_cal && (c5_reg == CYCLE_2100);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            wday6_reg <= wday5_reg;
            ys6_reg   <= BASE_YEAR + {c5_reg, 2'b00} + 8'(y1_reg);
            yday6_reg <= (is_2100 && doy_reg > LEAP_DAY) ? doy_reg - 9'd1 : doy_reg;
            d26_reg   <= (lp_cal && doy_reg >= LEAP_DAY) ? doy_reg - 9'd1 : doy_reg;
            feb6_reg  <= lp_cal && (doy_reg == LEAP_DAY);
        end
    end

    always_comb begin
        mon_next = 4'd0;
        for (int i = 1; i < 12; i++) begin
            mon_next = mon_next + 4'(d26_reg >= month_start(4'(i)));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            wday7_reg <= wday6_reg;
            ys7_reg   <= ys6_reg;
            yday7_reg <= yday6_reg;
            d27_reg   <= d26_reg;
            feb7_reg  <= feb6_reg;
            mon7_reg  <= mon_next;
        end
    end

    // February 29 shows up as February 28 plus one.
    assign mday_full = d27_reg - month_start(mon7_reg) + 9'd1 + 9'(feb7_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            date8_reg.weekday          <= wday7_reg;
            date8_reg.years_since_1900 <= ys7_reg;
            date8_reg.day_of_year      <= yday7_reg;
            date8_reg.month_index      <= mon7_reg;
            date8_reg.day_of_month     <= mday_full[4:0];
        end
    end

    assign date = date8_reg;

endmodule

[hw/rtl/epoch_seconds_to_calendar_top.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts unsigned seconds since 1970-01-01 00:00 to a Gregorian date/time.
// ----------------------------------------------------------------------------
// Usage: each word on the s_ channel carries one 32-bit second count; each
// word on the m_ channel carries the broken-down date and time for it, in
// the same order, one result per input word.
// The datapath is an eight-stage pipeline; divisions by constants are
// exact reciprocal multiplies. A new word can enter every cycle, so
// throughput is one word per cycle while the receiver keeps up.
// Each stage holds its word while the next stage cannot load, and bubbles
// close up, so s_tready only drops once every stage holds a word and the receiver
// stalls. Nothing is lost or repeated across a stall.
// Reset (aresetn low at a clock edge) empties the pipeline; no other state
// is kept between words.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
    // [45:41] day_of_month, [47:46] zero
    output logic [47:0] m_tdata
);
    import ecal_pkg::*;

    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] stage_en;
    logic [16:0]         day_secs;
    logic [15:0]         week_days;
    logic [15:0]         cycle_days;
    tod_t                tod;
    date_t               date;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb begin
        stage_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_tready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        valid_next[1] = stage_en[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    ecal_day_split u_day_split (
        .aclk          (aclk),
        .stage_en      (stage_en[2:1]),
        .epoch_seconds (s_tdata),
        .day_secs      (day_secs),
        .week_days     (week_days),
        .cycle_days    (cycle_days)
    );

    ecal_tod u_tod (
        .aclk     (aclk),
        .stage_en (stage_en[8:3]),
        .day_secs (day_secs),
        .tod      (tod)
    );

    ecal_date u_date (
        .aclk       (aclk),
        .stage_en   (stage_en[8:3]),
        .week_days  (week_days),
        .cycle_days (cycle_days),
        .date       (date)
    );

    assign s_tready = stage_en[1];
    assign m_tvalid = valid_reg[NUM_STAGES];
    assign m_tdata  = {2'b00,
                       date.day_of_month,
                       date.month_index,
                       date.day_of_year,
                       date.years_since_1900,
                       date.weekday,
                       tod.hour,
                       tod.minute,
                       tod.second};

endmodule

[dv/epoch_seconds_to_calendar_top_tb.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top_tb
// Streams second counts through the converter and checks every output word,
// field by field, against a calendar computed in the bench. Directed corners
// (epoch start, year ends, leap days, the skipped leap day of 2100, the top
// of the range) come first, then random words biased toward day and year
// boundaries. Both sides throttle at random, and there is one long
// receiver stall so that the pipeline fills up and backpressures the input.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top_tb;

    localparam int SECS_PER_DAY      = 86400;
    localparam int SECS_PER_HOUR     = 3600;
    localparam int SECS_PER_MIN      = 60;
    localparam int EPOCH_YEAR        = 1970;
    localparam int YEAR_BASE         = 1900;
    localparam int LEAP_DAY_INDEX    = 59;
    localparam int EPOCH_WEEKDAY     = 4;
    localparam int LAST_DAY          = 49710;
    localparam int RECV_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 24;
    localparam int CYCLE_LIMIT       = 200000;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [1:0] pad;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [31:0] pending_seconds[$];
    cal_word_t   expected_dates[$];
    cal_word_t   want_word;
    cal_word_t   got_word;
    int          send_idle_pct = 15;
    int          recv_idle_pct = 52;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          stall_left    = 0;
    logic        stall_start   = 1'b0;

    epoch_seconds_to_calendar_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m);
        case (m)
            1:       return 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic cal_word_t calendar_of(input logic [31:0] t);
        cal_word_t   r;
        int unsigned secs;
        int unsigned days;
        int unsigned rem;
        int unsigned year;
        int unsigned ylen;
        int unsigned mon;
        int unsigned mday;
        bit          leap;
        secs = t;
        days = secs / SECS_PER_DAY;
        rem  = secs % SECS_PER_DAY;
        r = '0;
        r.second  = 6'(rem % SECS_PER_MIN);
        r.minute  = 6'((rem / SECS_PER_MIN) % SECS_PER_MIN);
        r.hour    = 5'(rem / SECS_PER_HOUR);
        r.weekday = 3'((EPOCH_WEEKDAY + days) % 7);
        year = EPOCH_YEAR;
        forever begin
            ylen = is_leap_year(year) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            year++;
        end
        r.years_since_1900 = 8'(year - YEAR_BASE);
        r.day_of_year      = 9'(days);
        leap = is_leap_year(year);
        mday = 1;
        // February 29 keeps the February lookup, later days slide back one.
        if (leap && days == LEAP_DAY_INDEX) mday++;
        if (leap && days >= LEAP_DAY_INDEX) days--;
        mon = 0;
        while (mon < 11 && days >= month_length(mon)) begin
            days -= month_length(mon);
            mon++;
        end
        r.month_index  = 4'(mon);
        r.day_of_month = 5'(mday + days);
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Random second counts: a mix of uniform words, words at day edges and
    // words around the start of a year and the end of February.
    task automatic queue_random(input int n);
        longint d;
        longint v;
        int     y;
        int     kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                v = $urandom;
            end else begin
                if (kind < 7) begin
                    d = $urandom_range(LAST_DAY);
                end else begin
                    y = $urandom_range(2106, EPOCH_YEAR);
                    d = 0;
                    for (int k = EPOCH_YEAR; k < y; k++) d += is_leap_year(k) ? 366 : 365;
                    case ($urandom_range(6))
                        0:       d -= 1;
                        1:       d += 0;
                        2:       d += 58;
                        3:       d += 59;
                        4:       d += 60;
                        5:       d += 364;
                        default: d += 365;
                    endcase
                end
                case ($urandom_range(2))
                    0:       v = d * SECS_PER_DAY;
                    1:       v = d * SECS_PER_DAY + SECS_PER_DAY - 1;
                    default: v = d * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
                endcase
                if (v < 0) v = $urandom_range(SECS_PER_DAY - 1);
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF - $urandom_range(SECS_PER_DAY - 1);
            end
            pending_seconds.push_back(v[31:0]);
        end
    endtask

    task automatic wait_drained();
        while (pending_seconds.size() != 0 || s_tvalid || expected_dates.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: a word stays on the bus until it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_dates.push_back(calendar_of(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_seconds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_seconds.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_start) begin
            stall_left <= RECV_STALL_CYCLES;
        end
    end

    // Monitor: compares each output word with the oldest expected date.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_word = m_tdata;
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want_word = expected_dates.pop_front();
                    check_field("second", want_word.second, got_word.second);
                    check_field("minute", want_word.minute, got_word.minute);
                    check_field("hour", want_word.hour, got_word.hour);
                    check_field("weekday", want_word.weekday, got_word.weekday);
                    check_field("years_since_1900", want_word.years_since_1900,
                                got_word.years_since_1900);
                    check_field("day_of_year", want_word.day_of_year, got_word.day_of_year);
                    check_field("month_index", want_word.month_index, got_word.month_index);
                    check_field("day_of_month", want_word.day_of_month,
                                got_word.day_of_month);
                    check_field("pad", want_word.pad, got_word.pad);
                end
            end
            m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Epoch start, first day and first year edges.
        pending_seconds.push_back(32'd0);
        pending_seconds.push_back(32'd59);
        pending_seconds.push_back(32'd86399);
        pending_seconds.push_back(32'd86400);
        pending_seconds.push_back(32'd31535999);
        pending_seconds.push_back(32'd31536000);
        // Leap day of 1972 and its neighbors.
        pending_seconds.push_back(32'd68083200);
        pending_seconds.push_back(32'd68169600);
        pending_seconds.push_back(32'd68255999);
        pending_seconds.push_back(32'd68256000);
        // Year 2000 is a leap year despite the century rule.
        pending_seconds.push_back(32'd946684800);
        pending_seconds.push_back(32'd951782400);
        pending_seconds.push_back(32'd951868800);
        pending_seconds.push_back(32'd978220800);
        pending_seconds.push_back(32'd978307199);
        // Year 2100 has no leap day.
        pending_seconds.push_back(32'd4102444799);
        pending_seconds.push_back(32'd4102444800);
        pending_seconds.push_back(32'd4107456000);
        pending_seconds.push_back(32'd4107542400);
        pending_seconds.push_back(32'd4291747200);
        // Bit patterns and the top of the range.
        pending_seconds.push_back(32'h8000_0000);
        pending_seconds.push_back(32'h5555_5555);
        pending_seconds.push_back(32'hAAAA_AAAA);
        pending_seconds.push_back(32'hFFFF_FFFE);
        pending_seconds.push_back(32'hFFFF_FFFF);
        queue_random(470);
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 15;
        queue_random(230);
        // The sender holds back here until every result is in.
        wait_drained();
        queue_random(230);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200);
        // Long receiver stall while the sender keeps offering words.
        @(posedge aclk);
        stall_start <= 1'b1;
        @(posedge aclk);
        stall_start <= 1'b0;
        queue_random(250);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
